### rtl/c_comma_space_inserter_assert.svh
// Assertion macros used by the checker file ccsi_checker.sv
`ifndef C_COMMA_SPACE_INSERTER_ASSERT_SVH
`define C_COMMA_SPACE_INSERTER_ASSERT_SVH

// Check a property on the rising clock edge, ignored while reset is held
`define CCSI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, reset cycles included
`define CCSI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ccsi_pkg.sv
`default_nettype none

package ccsi_pkg;

    // Byte codes
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_SPACE  = 8'd32;

    // Plan queue geometry
    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    // Lexical mode
    typedef enum logic [3:0] {
        MODE_CODE   = 4'b0001,
        MODE_BLOCK  = 4'b0010,
        MODE_STRING = 4'b0100,
        MODE_LINE   = 4'b1000
    } t_mode;

    // One or two result bytes caused by one input byte
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;
        logic       err;
    } t_plan;

    // Whitespace: tab to carriage return, and space
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
    endfunction

endpackage

`default_nettype wire

### rtl/c_comma_space_inserter.sv
// Each result is registered in the plan queue and presented from its head entry.
// Throughput: one input byte per cycle while the plan queue is not full; a byte that causes
//   two results is given out as two output bytes, and the four-entry plan queue absorbs the difference.
// The first byte of a non-empty line only loads the lookahead register and gives no result.
// Reset (i_rst_n low, synchronous): code mode, nothing held, queue empty, not halted.
`default_nettype none

module c_comma_space_inserter (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_run_on_string
);

    ccsi_pkg::t_plan w_plan;
    ccsi_pkg::t_plan w_head;
    logic            w_plan_push;
    logic            w_deq;

    // Lexer and planner
    ccsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_full      (o_full),
        .i_in_byte   (i_in_byte),
        .o_plan      (w_plan),
        .o_plan_push (w_plan_push)
    );

    // Plan queue between front and back
    ccsi_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_plan_push),
        .i_wr_data (w_plan),
        .i_rd      (w_deq),
        .o_head    (w_head),
        .o_empty   (o_empty),
        .o_full    (o_full)
    );

    // Result sequencer
    ccsi_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_q_empty       (o_empty),
        .i_pop           (i_pop),
        .o_deq           (w_deq),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_run_on_string (o_run_on_string)
    );

endmodule

`default_nettype wire

### rtl/ccsi_front.sv
`default_nettype none

module ccsi_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire logic           i_full,
    input  wire logic [7:0]     i_in_byte,
    output ccsi_pkg::t_plan     o_plan,
    output logic                o_plan_push
);

    logic [7:0]      r_held_byte, n_held_byte;
    logic            r_held_valid, n_held_valid;
    ccsi_pkg::t_mode r_mode, n_mode;
    logic            r_halted, n_halted;
    logic            w_take;
    logic            w_plan_valid;

    assign w_take = i_push & ~i_full;

    // Classify the held byte against the new one and plan the results
    always_comb begin
        ccsi_pkg::t_mode mode_tmp;
        logic            pair;
        mode_tmp     = r_mode;
        pair         = 1'b0;
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_halted     = r_halted;
        o_plan       = '0;
        w_plan_valid = 1'b0;
        if (!r_halted) begin
            if (i_in_byte == ccsi_pkg::CH_NL) begin
                // End of line: flush the held byte without pairing
                w_plan_valid = 1'b1;
                if (r_held_valid) begin
                    o_plan.byte0 = r_held_byte;
                    o_plan.byte1 = ccsi_pkg::CH_NL;
                    o_plan.two   = 1'b1;
                    if (r_mode == ccsi_pkg::MODE_STRING &&
                        r_held_byte == ccsi_pkg::CH_DQUOTE) begin
                        mode_tmp = ccsi_pkg::MODE_CODE;
                    end
                    n_held_valid = 1'b0;
                    n_held_byte  = '0;
                end else begin
                    o_plan.byte0 = ccsi_pkg::CH_NL;
                end
                if (mode_tmp == ccsi_pkg::MODE_STRING) begin
                    o_plan.err = 1'b1;
                    n_halted   = 1'b1;
                end else if (mode_tmp == ccsi_pkg::MODE_LINE) begin
                    mode_tmp = ccsi_pkg::MODE_CODE;
                end
            end else if (!r_held_valid) begin
                // Nothing held: store only
                n_held_byte  = i_in_byte;
                n_held_valid = 1'b1;
            end else begin
                w_plan_valid = 1'b1;
                o_plan.byte0 = r_held_byte;
                n_held_byte  = i_in_byte;
                unique case (r_mode)
                    ccsi_pkg::MODE_CODE: begin
                        if (r_held_byte == ccsi_pkg::CH_COMMA &&
                            !ccsi_pkg::is_ws(i_in_byte)) begin
                            o_plan.byte1 = ccsi_pkg::CH_SPACE;
                            o_plan.two   = 1'b1;
                        end else if (r_held_byte == ccsi_pkg::CH_DQUOTE) begin
                            mode_tmp = ccsi_pkg::MODE_STRING;
                        end else if (r_held_byte == ccsi_pkg::CH_SLASH &&
                                     i_in_byte == ccsi_pkg::CH_STAR) begin
                            mode_tmp = ccsi_pkg::MODE_BLOCK;
                            pair     = 1'b1;
                        end else if (r_held_byte == ccsi_pkg::CH_SLASH &&
                                     i_in_byte == ccsi_pkg::CH_SLASH) begin
                            mode_tmp = ccsi_pkg::MODE_LINE;
                            pair     = 1'b1;
                        end
                    end
                    ccsi_pkg::MODE_BLOCK: begin
                        if (r_held_byte == ccsi_pkg::CH_STAR &&
                            i_in_byte == ccsi_pkg::CH_SLASH) begin
                            mode_tmp = ccsi_pkg::MODE_CODE;
                            pair     = 1'b1;
                        end
                    end
                    ccsi_pkg::MODE_STRING: begin
                        if (r_held_byte == ccsi_pkg::CH_BSLASH) begin
                            pair = 1'b1;
                        end else if (r_held_byte == ccsi_pkg::CH_DQUOTE) begin
                            mode_tmp = ccsi_pkg::MODE_CODE;
                        end
                    end
                    ccsi_pkg::MODE_LINE: begin
                    end
                    default: begin
                    end
                endcase
                // Consumed pair: emit both, hold nothing
                if (pair) begin
                    o_plan.byte1 = i_in_byte;
                    o_plan.two   = 1'b1;
                    n_held_valid = 1'b0;
                    n_held_byte  = '0;
                end
            end
        end
        n_mode = mode_tmp;
    end

    assign o_plan_push = w_take & w_plan_valid;

    // Advance the lexer on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_mode       <= ccsi_pkg::MODE_CODE;
            r_halted     <= 1'b0;
        end else if (w_take) begin
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_mode       <= n_mode;
            r_halted     <= n_halted;
        end
    end

endmodule

`default_nettype wire

### rtl/ccsi_queue.sv
`default_nettype none

module ccsi_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire ccsi_pkg::t_plan i_wr_data,
    input  wire logic           i_rd,
    output ccsi_pkg::t_plan     o_head,
    output logic                o_empty,
    output logic                o_full
);

    ccsi_pkg::t_plan                r_mem [ccsi_pkg::QDEPTH];
    logic [ccsi_pkg::PTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [ccsi_pkg::CNT_W-1:0]     r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == ccsi_pkg::CNT_W'(ccsi_pkg::QDEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    // Store the new plan entry
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and hold the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/ccsi_back.sv
`default_nettype none

module ccsi_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ccsi_pkg::t_plan i_head,
    input  wire logic           i_q_empty,
    input  wire logic           i_pop,
    output logic                o_deq,
    output logic [7:0]          o_out_byte,
    output logic                o_last_of_run,
    output logic                o_run_on_string
);

    logic r_phase, n_phase;
    logic w_xfer;

    assign w_xfer = i_pop & ~i_q_empty;

    // Present the current byte of the head entry
    assign o_out_byte      = r_phase ? i_head.byte1 : i_head.byte0;
    assign o_last_of_run   = ~i_head.two | r_phase;
    assign o_run_on_string = o_last_of_run & i_head.err;

    // Drop the entry after its last byte transfers
    assign o_deq = w_xfer & o_last_of_run;

    always_comb begin
        n_phase = r_phase;
        if (w_xfer) begin
            n_phase = i_head.two & ~r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

### rtl/ccsi_checker.sv
`default_nettype none
`include "c_comma_space_inserter_assert.svh"

module ccsi_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_full,
    input wire logic       i_pop,
    input wire logic       o_empty,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_last_of_run,
    input wire logic       o_run_on_string
);

    // Queue comes out of reset empty and open
    `CCSI_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (o_empty && !o_full), "not clear after reset")

    // A run-on string flag only marks the final result of a byte
    `CCSI_ASSERT(a_err_last, i_clk, i_rst_n, (!o_empty && o_run_on_string) |-> o_last_of_run, "run-on flag on non-final result")

    // After the run-on newline transfers nothing more is produced
    `CCSI_ASSERT(a_halt_quiet, i_clk, i_rst_n, (i_pop && !o_empty && o_run_on_string) |=> o_empty, "result after halt")

    // A non-final result is always followed by its partner
    `CCSI_ASSERT(a_run_cont, i_clk, i_rst_n, (i_pop && !o_empty && !o_last_of_run) |=> !o_empty, "run broken after non-final result")

    // A waiting result holds until transferred
    `CCSI_ASSERT(a_hold, i_clk, i_rst_n, (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_byte)), "waiting result changed")

endmodule

bind c_comma_space_inserter ccsi_checker u_ccsi_checker (.*);

`default_nettype wire
